FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the depth-buffer span block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define ZSW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("zsw: assertion failed");

// Concurrent assertion that is checked at every edge, reset included.
`define ZSW_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("zsw: assertion failed");

`endif

FILE: hdl/zsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsw_pkg
// Types and constants shared by the depth-buffer span writer modules.
// ----------------------------------------------------------------------------
package zsw_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 200;

    localparam int DEPTH_W  = 24;
    localparam int COLOUR_W = 16;
    localparam int PIXEL_W  = DEPTH_W + COLOUR_W;
    localparam int COUNT_W  = 11;

    // Dividend and divisor widths of the span setup divider.
    localparam int DIVIDEND_W = 45;
    localparam int DIVISOR_W  = 20;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SPAN  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_READ,
        S_READ_DATA,
        S_SETUP,
        S_MUL,
        S_DIV0_GO,
        S_DIV0_WAIT,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_DRAW,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: hdl/zsw_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsw_divider
// Restoring divider, one quotient bit per cycle, used during span setup.
// ----------------------------------------------------------------------------
module zsw_divider #(
    parameter int NW = zsw_pkg::DIVIDEND_W,
    parameter int DW = zsw_pkg::DIVISOR_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zsw_pkg::t_div_ctl i_ctl,
    input  logic [NW-1:0]     i_dividend,
    input  logic [DW-1:0]     i_divisor,
    output zsw_pkg::t_div_sts o_sts,
    output logic [NW-1:0]     o_quotient,
    output logic [DW-1:0]     o_remainder
);
    import zsw_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;

    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[NW-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? DW'(trial - {1'b0, r_div}) : trial[DW-1:0];
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: hdl/zsw_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsw_frame_mem
// Frame store: one depth and colour word per pixel, one write and one read port.
// ----------------------------------------------------------------------------
module zsw_frame_mem #(
    parameter int DEPTH = zsw_pkg::SCREEN_WIDTH_DEF * zsw_pkg::SCREEN_HEIGHT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = zsw_pkg::PIXEL_W
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    import zsw_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/zbuffer_span_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbuffer_span_writer_unit
// Depth-buffered span writer over a frame of depth and colour words.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives one result. A clear writes one
// pixel a cycle. A read at a pixel outside the frame skips the data step. A
// span is set up by two 45-step divisions that find the start depth and the
// per-pixel step, and then the single read-modify-write pass over the frame
// store handles one visible pixel per cycle; a span of zero width needs no
// division, and a span on a row outside the frame or with no visible pixel is
// not drawn. A finished result waits in the output register while the next
// transaction is accepted; while that register is still full the block holds
// its finished result and takes nothing new. Software must clear the frame
// before use.
module zbuffer_span_writer_unit #(
    parameter int SCREEN_WIDTH  = zsw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = zsw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_operation,
    input  logic [9:0]                     i_row,
    input  logic [9:0]                     i_pixel_column,
    input  logic signed [15:0]             i_x_start,
    input  logic [27:0]                    i_z_start,
    input  logic signed [15:0]             i_x_end,
    input  logic [27:0]                    i_z_end,
    input  logic [zsw_pkg::COLOUR_W-1:0]   i_pixel_colour,
    input  logic [zsw_pkg::DEPTH_W-1:0]    i_fill_depth,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [zsw_pkg::COLOUR_W-1:0]   o_read_colour,
    output logic [zsw_pkg::DEPTH_W-1:0]    o_read_depth,
    output logic [zsw_pkg::COUNT_W-1:0]    o_span_tested,
    output logic [zsw_pkg::COUNT_W-1:0]    o_span_drawn,
    output logic [zsw_pkg::DEPTH_W-1:0]    o_span_zmin,
    output logic [zsw_pkg::DEPTH_W-1:0]    o_span_zmax
);
    import zsw_pkg::*;

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int NW     = DIVIDEND_W;
    localparam int DVW    = DIVISOR_W;

    // Transaction registers
    logic [1:0]           r_op;
    logic [9:0]           r_row;
    logic [9:0]           r_col;
    logic signed [15:0]   r_xa;
    logic signed [15:0]   r_xb;
    logic [27:0]          r_za;
    logic [27:0]          r_zb;
    logic [COLOUR_W-1:0]  r_colour;
    logic [DEPTH_W-1:0]   r_fill;

    // Span setup and walk
    logic [9:0]           r_x;
    logic [9:0]           r_hi;
    logic [15:0]          r_w;
    logic [15:0]          r_u0;
    logic signed [28:0]   r_dz;
    logic [AW-1:0]        r_base;
    logic                 r_empty;
    logic [43:0]          r_p1;
    logic signed [45:0]   r_p2;
    logic signed [29:0]   r_q;
    logic [DVW-1:0]       r_r;
    logic signed [29:0]   r_qs;
    logic [DVW-1:0]       r_rs;

    // Compare stage
    logic                 r_p_valid;
    logic [AW-1:0]        r_p_addr;
    logic [DEPTH_W-1:0]   r_p_z;

    // Result under construction
    logic [COLOUR_W-1:0]  r_res_colour;
    logic [DEPTH_W-1:0]   r_res_depth;
    logic [COUNT_W-1:0]   r_tested;
    logic [COUNT_W-1:0]   r_drawn;
    logic [DEPTH_W-1:0]   r_zmin;
    logic [DEPTH_W-1:0]   r_zmax;

    // Output register
    logic                 r_out_valid;
    logic [COLOUR_W-1:0]  r_o_colour;
    logic [DEPTH_W-1:0]   r_o_depth;
    logic [COUNT_W-1:0]   r_o_tested;
    logic [COUNT_W-1:0]   r_o_drawn;
    logic [DEPTH_W-1:0]   r_o_zmin;
    logic [DEPTH_W-1:0]   r_o_zmax;

    logic [AW-1:0]        r_clr_addr;

    t_state               r_state;
    t_state               n_state;

    logic                 in_accept;
    logic                 swap;
    logic                 load_out;

    // Memory ports
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [PIXEL_W-1:0]   mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [PIXEL_W-1:0]   mem_rdata;

    // Divider
    t_div_ctl             div_ctl;
    t_div_sts             div_sts;
    logic [NW-1:0]        div_dividend;
    logic [DVW-1:0]       div_divisor;
    logic [NW-1:0]        div_quo;
    logic [DVW-1:0]       div_rem;

    // Setup arithmetic
    logic signed [16:0]   xa_e;
    logic signed [16:0]   xb_e;
    logic signed [16:0]   x0;
    logic signed [16:0]   x1f;
    logic signed [16:0]   x1;
    logic signed [16:0]   lo;
    logic signed [16:0]   hi;
    logic signed [16:0]   w_s;
    logic signed [18:0]   u_s;
    logic [15:0]          u0;
    logic                 row_in;
    logic [19:0]          row_base;
    logic [19:0]          read_addr;
    logic signed [46:0]   n0_s;
    logic [27:0]          dz_abs;
    logic [DVW-1:0]       d_full;
    logic [DVW:0]         r_sum;
    logic                 r_wrap;
    logic [DEPTH_W-1:0]   z_cur;
    logic                 pass;
    logic [24:0]          z_flat;

    assign in_accept = i_in_valid && o_in_ready;
    assign swap      = i_x_start > i_x_end;
    assign o_in_ready = (r_state == S_IDLE);

    assign row_in    = {1'b0, r_row} < 11'(SCREEN_HEIGHT);
    assign row_base  = 20'(r_row * SCREEN_WIDTH);
    assign read_addr = row_base + 20'(r_col);

    assign xa_e = {r_xa[15], r_xa};
    assign xb_e = {r_xb[15], r_xb};
    assign x0   = (xa_e - 17'sd8 + 17'sd15) >>> 4;
    assign x1f  = (xb_e - 17'sd8) >>> 4;
    assign x1   = (x1f < x0) ? x0 : x1f;
    assign lo   = (x0 < 17'sd0) ? 17'sd0 : x0;
    assign hi   = (x1 > 17'(SCREEN_WIDTH - 1)) ? 17'(SCREEN_WIDTH - 1) : x1;
    assign w_s  = xb_e - xa_e;
    // The offset of the first pixel is never negative; it passes the span
    // width only when a span shorter than a pixel is forced onto one column.
    assign u_s  = 19'({lo, 4'b0}) + 19'sd8 - {{3{r_xa[15]}}, r_xa};
    assign u0   = (u_s > {3'b0, w_s[15:0]}) ? w_s[15:0] : u_s[15:0];

    assign n0_s   = $signed({3'b0, r_p1}) + {r_p2[45], r_p2}
                  + $signed({28'b0, r_w, 3'b0});
    assign dz_abs = r_dz[28] ? 28'(-r_dz) : r_dz[27:0];
    assign d_full = {r_w, 4'b0};

    assign div_dividend = (r_state == S_DIV0_GO) ? n0_s[NW-1:0]
                                                 : NW'({dz_abs, 4'b0});
    assign div_divisor  = d_full;

    assign r_sum  = {1'b0, r_r} + {1'b0, r_rs};
    assign r_wrap = r_sum >= {1'b0, d_full};
    assign z_flat = r_q[24:0];
    assign z_cur  = (r_q > 30'sd16777215) ? DEPTH_MAX : z_flat[DEPTH_W-1:0];

    assign pass = r_p_z < mem_rdata[PIXEL_W-1:COLOUR_W];

    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p_addr;
        mem_wdata = {r_p_z, r_colour};
        mem_re    = 1'b0;
        mem_raddr = AW'(r_base + AW'(r_x));
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = {r_fill, r_colour};
        end else if (r_p_valid && pass) begin
            mem_we = 1'b1;
        end
        if (r_state == S_READ) begin
            mem_re    = 1'b1;
            mem_raddr = read_addr[AW-1:0];
        end else if (r_state == S_DRAW) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        div_ctl.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_op)
                    OP_CLEAR: n_state = S_CLEAR;
                    OP_READ:  n_state = S_READ;
                    OP_SPAN:  n_state = S_SETUP;
                    default:  n_state = S_DONE;
                endcase
            end
            S_CLEAR: begin
                if (r_clr_addr == AW'(PIXELS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (row_in && {1'b0, r_col} < 11'(SCREEN_WIDTH)) begin
                    n_state = S_READ_DATA;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ_DATA: begin
                n_state = S_DONE;
            end
            S_SETUP: begin
                if (!row_in || lo > hi) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = (r_w == 16'd0) ? S_DRAW : S_DIV0_GO;
            end
            S_DIV0_GO: begin
                div_ctl.start = 1'b1;
                n_state       = S_DIV0_WAIT;
            end
            S_DIV0_WAIT: begin
                if (div_sts.done) begin
                    n_state = S_DIV1_GO;
                end
            end
            S_DIV1_GO: begin
                div_ctl.start = 1'b1;
                n_state       = S_DIV1_WAIT;
            end
            S_DIV1_WAIT: begin
                if (div_sts.done) begin
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (r_x == r_hi) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= i_operation;
            r_row    <= i_row;
            r_col    <= i_pixel_column;
            r_xa     <= swap ? i_x_end : i_x_start;
            r_xb     <= swap ? i_x_start : i_x_end;
            r_za     <= swap ? i_z_end : i_z_start;
            r_zb     <= swap ? i_z_start : i_z_end;
            r_colour <= i_pixel_colour;
            r_fill   <= i_fill_depth;
            r_res_colour <= '0;
            r_res_depth  <= '0;
            r_tested     <= '0;
            r_drawn      <= '0;
            r_zmin       <= DEPTH_MAX;
            r_zmax       <= '0;
            r_clr_addr   <= '0;
        end

        case (r_state)
            S_CLEAR: begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            S_READ_DATA: begin
                r_res_colour <= mem_rdata[COLOUR_W-1:0];
                r_res_depth  <= mem_rdata[PIXEL_W-1:COLOUR_W];
            end
            S_SETUP: begin
                r_x     <= lo[9:0];
                r_hi    <= hi[9:0];
                r_w     <= w_s[15:0];
                r_u0    <= u0;
                r_dz    <= $signed({1'b0, r_zb}) - $signed({1'b0, r_za});
                r_base  <= row_base[AW-1:0];
                r_empty <= !row_in || lo > hi;
            end
            S_MUL: begin
                r_p1 <= r_za * r_w;
                r_p2 <= 46'(r_dz * $signed({1'b0, r_u0}));
                // Zero-width span: depth is the rounded start depth.
                r_q  <= 30'((r_za + 28'd8) >> 4) | 30'(r_za[27:4] == 24'hFFFFFF
                        && r_za[3:0] >= 4'd8 ? 30'h1000000 : 30'd0);
                r_r  <= '0;
                r_qs <= '0;
                r_rs <= '0;
            end
            S_DIV1_GO: begin
                r_q <= $signed(div_quo[29:0]);
                r_r <= div_rem;
            end
            S_DIV1_WAIT: begin
                if (div_sts.done) begin
                    if (!r_dz[28]) begin
                        r_qs <= $signed(div_quo[29:0]);
                        r_rs <= div_rem;
                    end else if (div_rem == '0) begin
                        r_qs <= -$signed(div_quo[29:0]);
                        r_rs <= '0;
                    end else begin
                        r_qs <= -$signed(div_quo[29:0]) - 30'sd1;
                        r_rs <= d_full - div_rem;
                    end
                end
            end
            S_DRAW: begin
                r_x <= r_x + 1'b1;
                if (r_wrap) begin
                    r_r <= DVW'(r_sum - {1'b0, d_full});
                    r_q <= r_q + r_qs + 30'sd1;
                end else begin
                    r_r <= r_sum[DVW-1:0];
                    r_q <= r_q + r_qs;
                end
            end
            default: ;
        endcase

        r_p_addr <= AW'(r_base + AW'(r_x));
        r_p_z    <= z_cur;
        if (r_p_valid) begin
            r_tested <= r_tested + 1'b1;
            if (r_p_z < r_zmin) r_zmin <= r_p_z;
            if (r_p_z > r_zmax) r_zmax <= r_p_z;
            if (pass) r_drawn <= r_drawn + 1'b1;
        end

        if (load_out) begin
            r_o_colour <= r_res_colour;
            r_o_depth  <= r_res_depth;
            r_o_tested <= r_tested;
            r_o_drawn  <= r_drawn;
            r_o_zmin   <= r_zmin;
            r_o_zmax   <= r_zmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p_valid <= (r_state == S_DRAW) && !r_empty;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    zsw_divider #(
        .NW (NW),
        .DW (DVW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_sts       (div_sts),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    zsw_frame_mem #(
        .DEPTH (PIXELS),
        .AW    (AW),
        .DW    (PIXEL_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_read_colour = r_o_colour;
    assign o_read_depth  = r_o_depth;
    assign o_span_tested = r_o_tested;
    assign o_span_drawn  = r_o_drawn;
    assign o_span_zmin   = r_o_zmin;
    assign o_span_zmax   = r_o_zmax;

endmodule

FILE: hdl/zsw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsw_checker
// Port-level checks for the depth-buffer span writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zsw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [zsw_pkg::COLOUR_W-1:0] o_read_colour,
    input logic [zsw_pkg::DEPTH_W-1:0]  o_read_depth,
    input logic [zsw_pkg::COUNT_W-1:0]  o_span_tested,
    input logic [zsw_pkg::COUNT_W-1:0]  o_span_drawn,
    input logic [zsw_pkg::DEPTH_W-1:0]  o_span_zmin,
    input logic [zsw_pkg::DEPTH_W-1:0]  o_span_zmax
);
    import zsw_pkg::*;

    // Reset leaves the block empty and ready for a transaction.
    `ZSW_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)

    // A stalled result holds.
    `ZSW_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_span_tested) && $stable(o_span_drawn) && $stable(o_read_depth) && $stable(o_read_colour))

    // Only one transaction is in the block at a time.
    `ZSW_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    `ZSW_ASSERT(a_drawn_le_tested, i_clk, i_rst_n, o_out_valid |-> o_span_drawn <= o_span_tested)

    // With no tested pixel the depth range stays at its empty values.
    `ZSW_ASSERT(a_empty_range, i_clk, i_rst_n, o_out_valid && o_span_tested == '0 |-> o_span_zmin == DEPTH_MAX && o_span_zmax == '0)

endmodule

bind zbuffer_span_writer_unit zsw_checker u_zsw_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth-buffered span writer. A directed table
// covers clears, reads at the frame edges, the unused code, spans off the
// frame, reversed ends, zero width and depth saturation. Random clears, spans
// and reads follow, with idling on both channels and one long output stall.
// Each result is checked against a software copy of the frame or a table value.
// ----------------------------------------------------------------------------
module tb_top;
    import zsw_pkg::*;

    localparam int  WIDTH      = SCREEN_WIDTH_DEF;
    localparam int  HEIGHT     = SCREEN_HEIGHT_DEF;
    localparam int  PIXELS     = WIDTH * HEIGHT;
    localparam int  N_RANDOM   = 800;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [15:0] xa;
        logic [27:0]        za;
        logic signed [15:0] xb;
        logic [27:0]        zb;
        logic [15:0]        colour;
        logic [23:0]        fill;
    } t_item;

    typedef struct packed {
        logic [15:0] rc;
        logic [23:0] rd;
        logic [10:0] tested;
        logic [10:0] drawn;
        logic [23:0] zmin;
        logic [23:0] zmax;
    } t_res;

    typedef struct {
        t_item it;
        bit    typed;
        t_res  res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  in_op = '0;
    logic [9:0]  in_row = '0;
    logic [9:0]  in_col = '0;
    logic signed [15:0] in_xa = '0;
    logic [27:0] in_za = '0;
    logic signed [15:0] in_xb = '0;
    logic [27:0] in_zb = '0;
    logic [15:0] in_colour = '0;
    logic [23:0] in_fill = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] o_read_colour;
    logic [23:0] o_read_depth;
    logic [10:0] o_span_tested;
    logic [10:0] o_span_drawn;
    logic [23:0] o_span_zmin;
    logic [23:0] o_span_zmax;

    logic [23:0] frame_depth [PIXELS];
    logic [15:0] frame_colour [PIXELS];
    t_res        pending_results [$];
    t_row        directed [$];
    int          mismatches = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          hold_request = 0;
    longint      cycles = 0;

    always #5 i_clk = ~i_clk;

    zbuffer_span_writer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (in_op),
        .i_row          (in_row),
        .i_pixel_column (in_col),
        .i_x_start      (in_xa),
        .i_z_start      (in_za),
        .i_x_end        (in_xb),
        .i_z_end        (in_zb),
        .i_pixel_colour (in_colour),
        .i_fill_depth   (in_fill),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_read_colour  (o_read_colour),
        .o_read_depth   (o_read_depth),
        .o_span_tested  (o_span_tested),
        .o_span_drawn   (o_span_drawn),
        .o_span_zmin    (o_span_zmin),
        .o_span_zmax    (o_span_zmax)
    );

    function automatic longint floor16(longint n);
        return n >= 0 ? n / 16 : -((-n + 15) / 16);
    endfunction

    function automatic longint ceil16(longint n);
        return n >= 0 ? (n + 15) / 16 : -((-n) / 16);
    endfunction

    // Applies one transaction to the frame copy and returns its result.
    function automatic t_res frame_apply(t_item it);
        t_res   r;
        longint xa, xb, za, zb, s, x0, x1, lo, hi, w, u, d;
        int     idx;
        r = '{rc: '0, rd: '0, tested: '0, drawn: '0, zmin: DEPTH_MAX, zmax: '0};
        if (it.op == OP_CLEAR) begin
            for (int i = 0; i < PIXELS; i++) begin
                frame_depth[i]  = it.fill;
                frame_colour[i] = it.colour;
            end
        end else if (it.op == OP_READ) begin
            if (it.row < HEIGHT && it.col < WIDTH) begin
                idx  = it.row * WIDTH + it.col;
                r.rc = frame_colour[idx];
                r.rd = frame_depth[idx];
            end
        end else if (it.op == OP_SPAN && it.row < HEIGHT) begin
            xa = it.xa;
            xb = it.xb;
            za = it.za;
            zb = it.zb;
            if (xa > xb) begin
                s = xa; xa = xb; xb = s;
                s = za; za = zb; zb = s;
            end
            x0 = ceil16(xa - 8);
            x1 = floor16(xb - 8);
            if (x1 < x0) x1 = x0;
            w  = xb - xa;
            lo = x0 < 0 ? 0 : x0;
            hi = x1 > WIDTH - 1 ? WIDTH - 1 : x1;
            for (longint x = lo; x <= hi; x++) begin
                if (w == 0) begin
                    d = (za + 8) / 16;
                end else begin
                    u = 16 * x + 8 - xa;
                    if (u < 0) u = 0;
                    if (u > w) u = w;
                    d = (za * w + (zb - za) * u + 8 * w) / (16 * w);
                end
                if (d > longint'(DEPTH_MAX)) d = longint'(DEPTH_MAX);
                idx = it.row * WIDTH + int'(x);
                r.tested++;
                if (d < r.zmin) r.zmin = d[23:0];
                if (d > r.zmax) r.zmax = d[23:0];
                if (d < frame_depth[idx]) begin
                    frame_depth[idx]  = d[23:0];
                    frame_colour[idx] = it.colour;
                    r.drawn++;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Drives one transaction and holds it until the block takes it.
    task automatic drive_item(t_item it, bit typed, t_res typed_res);
        t_res predicted;
        bit   ready_seen;
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_op     <= it.op;
        in_row    <= it.row;
        in_col    <= it.col;
        in_xa     <= it.xa;
        in_za     <= it.za;
        in_xb     <= it.xb;
        in_zb     <= it.zb;
        in_colour <= it.colour;
        in_fill   <= it.fill;
        predicted = frame_apply(it);
        pending_results.push_back(typed ? typed_res : predicted);
        do begin
            @(negedge i_clk);
            ready_seen = o_in_ready;
            @(posedge i_clk);
        end while (!ready_seen);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("zbuffer_span_writer_unit test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_request != 0 && hold_left == 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_read_colour !== want.rc)
                    report_mismatch("read_colour", o_read_colour, want.rc);
                if (o_read_depth !== want.rd)
                    report_mismatch("read_depth", o_read_depth, want.rd);
                if (o_span_tested !== want.tested)
                    report_mismatch("span_tested", o_span_tested, want.tested);
                if (o_span_drawn !== want.drawn)
                    report_mismatch("span_drawn", o_span_drawn, want.drawn);
                if (o_span_zmin !== want.zmin)
                    report_mismatch("span_zmin", o_span_zmin, want.zmin);
                if (o_span_zmax !== want.zmax)
                    report_mismatch("span_zmax", o_span_zmax, want.zmax);
            end
        end
    end

    task automatic add_row(logic [1:0] op, int row, int col, int xa, int za, int xb, int zb,
                           int colour, int fill, bit typed, t_res res);
        t_row r;
        r.it    = '{op, row[9:0], col[9:0], xa[15:0], za[27:0], xb[15:0], zb[27:0],
                    colour[15:0], fill[23:0]};
        r.typed = typed;
        r.res   = res;
        directed.push_back(r);
    endtask

    function automatic t_item random_item(int n, int last_row);
        t_item it;
        int    pick;
        it.op     = OP_SPAN;
        it.row    = 10'($urandom_range(HEIGHT - 1));
        it.col    = 10'($urandom_range(WIDTH - 1));
        it.xa     = 16'($urandom_range(0, 5760) - 320);
        it.xb     = 16'($urandom_range(0, 5760) - 320);
        it.za     = 28'($urandom);
        it.zb     = 28'($urandom);
        it.colour = 16'($urandom);
        it.fill   = 24'($urandom);
        pick = $urandom_range(99);
        if (n % 200 == 199) begin
            it.op = OP_CLEAR;
        end else if (pick < 3) begin
            it.op = OP_UNUSED;
        end else if (pick < 33) begin
            it.op = OP_READ;
            // Mostly read back the row that was just drawn.
            if ($urandom_range(3) != 0) it.row = 10'(last_row);
        end
        if ($urandom_range(9) == 0) it.row = 10'($urandom);
        if ($urandom_range(9) == 0) it.col = 10'($urandom);
        if ($urandom_range(9) == 0) it.xa = 16'($urandom);
        if ($urandom_range(9) == 0) it.xb = 16'($urandom);
        if ($urandom_range(15) == 0) it.xb = it.xa;
        if ($urandom_range(7) == 0) it.za = 28'($urandom_range(0, 1000));
        return it;
    endfunction

    initial begin
        t_res  none;
        t_res  r;
        t_item it;
        int    last_row;
        none = '{rc: '0, rd: '0, tested: '0, drawn: '0, zmin: DEPTH_MAX, zmax: '0};

        add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 'hABCD, 'hFFFFFF, 1, none);
        r = none; r.rc = 'hABCD; r.rd = 'hFFFFFF;
        add_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, r);
        add_row(OP_READ, HEIGHT - 1, WIDTH - 1, 0, 0, 0, 0, 0, 0, 1, r);
        add_row(OP_READ, 5, 1023, 0, 0, 0, 0, 0, 0, 1, none);
        add_row(OP_READ, 1023, 5, 0, 0, 0, 0, 0, 0, 1, none);
        add_row(OP_UNUSED, 7, 7, 100, 5, 200, 9, 'h1234, 'h55, 1, none);
        add_row(OP_SPAN, 1023, 0, 0, 0, 5000, 0, 'h1111, 0, 1, none);
        add_row(OP_SPAN, 10, 0, 0, 0, 5119, 'hFFFFFFF, 'h2222, 0, 0, none);
        add_row(OP_SPAN, 11, 0, 5119, 0, 0, 'hFFFFFFF, 'h3333, 0, 0, none);
        add_row(OP_SPAN, 20, 0, 100, 'hFFFFFFF, 100, 0, 'h4444, 0, 0, none);
        add_row(OP_SPAN, HEIGHT - 1, 0, -32768, 0, 32767, 'hFFFFFFF, 'hFFFF, 0, 0, none);
        add_row(OP_SPAN, 3, 0, -800, 50, -200, 60, 'h5555, 0, 0, none);
        add_row(OP_SPAN, 4, 0, 32767, 50, 32000, 60, 'h6666, 0, 0, none);
        add_row(OP_SPAN, 12, 0, 37, 0, 45, 0, 'h7777, 0, 0, none);
        add_row(OP_READ, 10, 0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(OP_READ, 11, 319, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 'h0000, 'h000000, 1, none);
        add_row(OP_SPAN, 0, 0, 0, 0, 800, 'h7FFF, 'h8888, 0, 0, none);
        add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 'hFFFF, 'hFFFFFF, 1, none);

        snd_idle = 13;
        rcv_idle = 48;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) drive_item(directed[i].it, directed[i].typed, directed[i].res);

        // Long output stall so that the block fills up and refuses input.
        hold_request = 3000;
        last_row = 10;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                snd_idle = 48;
                rcv_idle = 13;
            end else if (n == 2 * N_RANDOM / 3) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            it = random_item(n, last_row);
            if (it.op == OP_SPAN) last_row = it.row;
            drive_item(it, 0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("zbuffer_span_writer_unit test passed");
        end else begin
            $display("zbuffer_span_writer_unit test failed");
        end
        $finish;
    end

endmodule

FILE: zbuffer_span_writer_unit.f
+incdir+hdl
hdl/zsw_pkg.sv
hdl/zsw_divider.sv
hdl/zsw_frame_mem.sv
hdl/zbuffer_span_writer_unit.sv
hdl/zsw_checker.sv
test/tb_top.sv
